// File: rtl/thrc_pkg.sv
package thrc_pkg;

  localparam int unsigned COUNT_WIDTH = 16;

  typedef logic [COUNT_WIDTH-1:0] cnt_t;

  // Request codes
  localparam logic [1:0] REQ_PRESS  = 2'd0;
  localparam logic [1:0] REQ_TICK   = 2'd1;
  localparam logic [1:0] REQ_LOCK   = 2'd2;
  localparam logic [1:0] REQ_UNLOCK = 2'd3;

  // Button hold state
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RIGHT = 2'd1;
  localparam logic [1:0] ST_LEFT  = 2'd2;
  localparam logic [1:0] ST_BOTH  = 2'd3;

  // Adjust modes
  localparam logic [1:0] MODE_CENTER = 2'd0;
  localparam logic [1:0] MODE_SPAN   = 2'd1;
  localparam logic [1:0] MODE_LOCK   = 2'd2;

  // Commands
  localparam logic [2:0] CMD_NONE      = 3'd0;
  localparam logic [2:0] CMD_DEC       = 3'd1;
  localparam logic [2:0] CMD_INC       = 3'd2;
  localparam logic [2:0] CMD_FAST_DEC  = 3'd3;
  localparam logic [2:0] CMD_FAST_INC  = 3'd4;
  localparam logic [2:0] CMD_INC_SPAN  = 3'd5;
  localparam logic [2:0] CMD_DEC_SPAN  = 3'd6;
  localparam logic [2:0] CMD_NEXT_BAND = 3'd7;

  // Register indexes
  localparam logic [1:0] REG_REPEAT = 2'd0;
  localparam logic [1:0] REG_FAST   = 2'd1;
  localparam logic [1:0] REG_BOTH   = 2'd2;

  localparam logic [7:0] REPEAT_RESET = 8'd3;
  localparam logic [7:0] FAST_RESET   = 8'd50;
  localparam logic [7:0] BOTH_RESET   = 8'd40;

  typedef struct packed {
    logic [1:0] held;
    cnt_t       ticks;
    logic [1:0] mode;
    logic       mode_saved;
    logic       timer_run;
  } thrc_state_t;

  typedef struct packed {
    logic [7:0] repeat_start;
    logic [7:0] fast_start;
    logic [7:0] both_hold;
  } thrc_cfg_t;

endpackage

// File: rtl/thrc_step.sv
module thrc_step (
  input  thrc_pkg::thrc_state_t state,
  input  thrc_pkg::thrc_cfg_t   cfg,
  input  logic [1:0]            req_type,
  input  logic [1:0]            levels,
  output thrc_pkg::thrc_state_t state_nxt,
  output logic [2:0]            command,
  output logic                  display_update
);

  thrc_pkg::cnt_t cnt_inc;
  logic [1:0]     lv_state;
  logic           is_left;
  logic           step_hit;
  logic           fast_hit;

  function automatic logic [2:0] single_cmd(input logic [1:0] mode, input logic left,
                                            input logic fast);
    logic [2:0] c;
    c = thrc_pkg::CMD_NONE;
    case (mode)
      thrc_pkg::MODE_CENTER: begin
        if (left) c = fast ? thrc_pkg::CMD_FAST_DEC : thrc_pkg::CMD_DEC;
        else      c = fast ? thrc_pkg::CMD_FAST_INC : thrc_pkg::CMD_INC;
      end
      thrc_pkg::MODE_SPAN: begin
        c = left ? thrc_pkg::CMD_INC_SPAN : thrc_pkg::CMD_DEC_SPAN;
      end
      default: c = thrc_pkg::CMD_NONE;
    endcase
    return c;
  endfunction

  always_comb begin
    case (levels)
      2'b01:   lv_state = thrc_pkg::ST_LEFT;
      2'b10:   lv_state = thrc_pkg::ST_RIGHT;
      2'b11:   lv_state = thrc_pkg::ST_BOTH;
      default: lv_state = thrc_pkg::ST_IDLE;
    endcase
  end

  // Saturating hold count
  assign cnt_inc = (&state.ticks) ? state.ticks : state.ticks + thrc_pkg::cnt_t'(1);

  assign is_left  = (state.held == thrc_pkg::ST_LEFT);
  assign fast_hit = (cnt_inc >= thrc_pkg::cnt_t'(cfg.fast_start));
  assign step_hit = (cnt_inc == '0) ||
                    ((cnt_inc >= thrc_pkg::cnt_t'(cfg.repeat_start)) && !fast_hit);

  always_comb begin
    state_nxt      = state;
    command        = thrc_pkg::CMD_NONE;
    display_update = 1'b0;
    case (req_type)
      thrc_pkg::REQ_PRESS: begin
        if (lv_state != thrc_pkg::ST_IDLE) begin
          state_nxt.held      = lv_state;
          state_nxt.ticks     = '0;
          state_nxt.timer_run = 1'b1;
        end
      end
      thrc_pkg::REQ_TICK: begin
        state_nxt.ticks     = cnt_inc;
        state_nxt.timer_run = 1'b1;
        state_nxt.held      = lv_state;
        case (state.held)
          thrc_pkg::ST_IDLE: begin
            state_nxt.ticks     = '0;
            state_nxt.timer_run = 1'b0;
          end
          thrc_pkg::ST_LEFT, thrc_pkg::ST_RIGHT: begin
            if (step_hit)      command = single_cmd(state.mode, is_left, 1'b0);
            else if (fast_hit) command = single_cmd(state.mode, is_left, 1'b1);
          end
          default: begin
            if (cnt_inc >= thrc_pkg::cnt_t'(cfg.both_hold)) begin
              command        = thrc_pkg::CMD_NEXT_BAND;
              state_nxt.held = thrc_pkg::ST_IDLE;
            end else if (lv_state == thrc_pkg::ST_IDLE) begin
              // Early release of both buttons: swap center and span
              if (state.mode == thrc_pkg::MODE_CENTER)    state_nxt.mode = thrc_pkg::MODE_SPAN;
              else if (state.mode == thrc_pkg::MODE_SPAN) state_nxt.mode = thrc_pkg::MODE_CENTER;
              display_update = 1'b1;
            end
          end
        endcase
      end
      thrc_pkg::REQ_LOCK: begin
        if (state.mode != thrc_pkg::MODE_LOCK) begin
          state_nxt.mode_saved = state.mode[0];
          state_nxt.mode       = thrc_pkg::MODE_LOCK;
        end
        display_update = 1'b1;
      end
      default: begin
        if (state.mode == thrc_pkg::MODE_LOCK) state_nxt.mode = {1'b0, state.mode_saved};
        display_update = 1'b1;
      end
    endcase
  end

endmodule

// File: rtl/two_button_hold_repeat_controller.sv
// Two-button hold/repeat controller. Each input item is a press edge, a
// debounce tick, a lock or an unlock request together with the pressed levels
// of the left (bit 0) and right (bit 1) buttons; each item yields exactly one
// result item carrying the command, the adjust mode after the item, a display
// refresh flag, the tick-timer run flag and the held-button state. The block
// takes one item per clock unless in_stall is high: the button, hold-count and
// mode state update at the edge that accepts an item and the result lands in
// an output register at that edge, to be seen in the next cycle.
// in_stall rises only when that output register holds a result the consumer
// is stalling. Thresholds live in three 8-bit registers on the APB port
// (0x0 repeat start, 0x4 fast start, 0x8 both-button hold); write them only
// while no item is in flight. A threshold of zero is honored as written.
module two_button_hold_repeat_controller (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_req_type,
  input  logic [1:0]  in_buttons_pressed,
  // Result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_command,
  output logic [1:0]  out_adjust_mode,
  output logic        out_display_update,
  output logic        out_tick_timer_run,
  output logic [1:0]  out_held_buttons,
  // Configuration port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  thrc_pkg::thrc_cfg_t   cfg_r;
  thrc_pkg::thrc_state_t state_r;
  thrc_pkg::thrc_state_t state_nxt;
  logic [2:0]            command_nxt;
  logic                  disp_nxt;
  logic                  in_accept;
  logic                  cfg_wr;

  logic                  out_valid_r;
  logic [2:0]            command_r;
  logic [1:0]            mode_r;
  logic                  disp_r;
  logic                  timer_r;
  logic [1:0]            held_r;

  // Configuration registers
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.repeat_start <= thrc_pkg::REPEAT_RESET;
      cfg_r.fast_start   <= thrc_pkg::FAST_RESET;
      cfg_r.both_hold    <= thrc_pkg::BOTH_RESET;
    end else if (cfg_wr) begin
      case (cfg_paddr[3:2])
        thrc_pkg::REG_REPEAT: cfg_r.repeat_start <= cfg_pwdata[7:0];
        thrc_pkg::REG_FAST:   cfg_r.fast_start   <= cfg_pwdata[7:0];
        thrc_pkg::REG_BOTH:   cfg_r.both_hold    <= cfg_pwdata[7:0];
        default: ;  // unmapped address: drop the write
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      thrc_pkg::REG_REPEAT: cfg_prdata = {24'd0, cfg_r.repeat_start};
      thrc_pkg::REG_FAST:   cfg_prdata = {24'd0, cfg_r.fast_start};
      thrc_pkg::REG_BOTH:   cfg_prdata = {24'd0, cfg_r.both_hold};
      default:              cfg_prdata = 32'd0;
    endcase
  end

  // Hold off new items only while a finished result is stalled
  assign in_stall  = out_valid_r && out_stall;
  assign in_accept = in_valid && !in_stall;

  thrc_step u_step (
    .state          (state_r),
    .cfg            (cfg_r),
    .req_type       (in_req_type),
    .levels         (in_buttons_pressed),
    .state_nxt      (state_nxt),
    .command        (command_nxt),
    .display_update (disp_nxt)
  );

  // Controller state: advance on every accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.held       <= thrc_pkg::ST_IDLE;
      state_r.ticks      <= '0;
      state_r.mode       <= thrc_pkg::MODE_CENTER;
      state_r.mode_saved <= 1'b0;
      state_r.timer_run  <= 1'b0;
    end else if (in_accept) begin
      state_r <= state_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      command_r <= command_nxt;
      mode_r    <= state_nxt.mode;
      disp_r    <= disp_nxt;
      timer_r   <= state_nxt.timer_run;
      held_r    <= state_nxt.held;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_command        = command_r;
  assign out_adjust_mode    = mode_r;
  assign out_display_update = disp_r;
  assign out_tick_timer_run = timer_r;
  assign out_held_buttons   = held_r;

`ifndef SYNTHESIS
  // A lock request always leaves the block locked
  a_lock_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_req_type == thrc_pkg::REQ_LOCK)
      |=> (state_r.mode == thrc_pkg::MODE_LOCK))
    else $error("lock request did not lock the mode");

  // Next band always drops the held state back to idle
  a_next_band_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && command_r == thrc_pkg::CMD_NEXT_BAND)
      |-> (held_r == thrc_pkg::ST_IDLE))
    else $error("next band issued with buttons still held");

  // A stopped timer implies a cleared hold count
  a_timer_count: assert property (@(posedge clk) disable iff (!rst_n)
    !state_r.timer_run |-> (state_r.ticks == '0))
    else $error("hold count nonzero while timer stopped");

  // Back-pressure only comes from a held result
  a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid_r)
    else $error("input stalled with empty result register");
`endif

endmodule

// File: tb/hold_repeat_checker.sv
module hold_repeat_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  in_req_type,
  input  logic [1:0]  in_buttons_pressed,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [2:0]  out_command,
  input  logic [1:0]  out_adjust_mode,
  input  logic        out_display_update,
  input  logic        out_tick_timer_run,
  input  logic [1:0]  out_held_buttons,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  input  logic        cfg_pready,
  output int          mismatches,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [2:0] cmd;
    logic [1:0] mode;
    logic       disp;
    logic       timer;
    logic [1:0] held;
  } ctrl_result_t;

  ctrl_result_t predicted_results[$];

  // Controller state and thresholds as the block should hold them
  logic [1:0]     btn_state;
  thrc_pkg::cnt_t hold_cnt;
  logic [1:0]     adj_mode;
  logic           saved_mode;
  logic           timer_on;
  logic [7:0]     repeat_thr;
  logic [7:0]     fast_thr;
  logic [7:0]     both_thr;

  function automatic logic [1:0] levels_to_held(logic [1:0] lv);
    case (lv)
      2'b01: return thrc_pkg::ST_LEFT;
      2'b10: return thrc_pkg::ST_RIGHT;
      2'b11: return thrc_pkg::ST_BOTH;
      default: return thrc_pkg::ST_IDLE;
    endcase
  endfunction

  function automatic logic [2:0] single_button_cmd(logic [1:0] mode, logic left, logic fast);
    if (mode == thrc_pkg::MODE_CENTER) begin
      if (left) return fast ? thrc_pkg::CMD_FAST_DEC : thrc_pkg::CMD_DEC;
      return fast ? thrc_pkg::CMD_FAST_INC : thrc_pkg::CMD_INC;
    end
    if (mode == thrc_pkg::MODE_SPAN) return left ? thrc_pkg::CMD_INC_SPAN : thrc_pkg::CMD_DEC_SPAN;
    return thrc_pkg::CMD_NONE;
  endfunction

  task automatic predict_result(input logic [1:0] req, input logic [1:0] lv,
                                output ctrl_result_t r);
    logic [1:0]     nxt;
    thrc_pkg::cnt_t cnt;
    logic [2:0]     cmd;
    logic           disp;
    cmd  = thrc_pkg::CMD_NONE;
    disp = 1'b0;
    nxt  = levels_to_held(lv);
    case (req)
      thrc_pkg::REQ_PRESS: begin
        if (nxt != thrc_pkg::ST_IDLE) begin
          btn_state = nxt;
          hold_cnt  = '0;
          timer_on  = 1'b1;
        end
      end
      thrc_pkg::REQ_TICK: begin
        if (hold_cnt != '1) hold_cnt = hold_cnt + thrc_pkg::cnt_t'(1);
        timer_on = 1'b1;
        cnt = hold_cnt;
        case (btn_state)
          thrc_pkg::ST_IDLE: begin
            hold_cnt = '0;
            timer_on = 1'b0;
          end
          thrc_pkg::ST_RIGHT, thrc_pkg::ST_LEFT: begin
            if (cnt == '0 || (cnt >= thrc_pkg::cnt_t'(repeat_thr) &&
                              cnt < thrc_pkg::cnt_t'(fast_thr)))
              cmd = single_button_cmd(adj_mode, btn_state == thrc_pkg::ST_LEFT, 1'b0);
            else if (cnt >= thrc_pkg::cnt_t'(fast_thr))
              cmd = single_button_cmd(adj_mode, btn_state == thrc_pkg::ST_LEFT, 1'b1);
          end
          default: begin
            if (cnt >= thrc_pkg::cnt_t'(both_thr)) begin
              cmd = thrc_pkg::CMD_NEXT_BAND;
              nxt = thrc_pkg::ST_IDLE;
            end else if (nxt == thrc_pkg::ST_IDLE) begin
              // early release of both buttons flips center and span
              if (adj_mode == thrc_pkg::MODE_CENTER) adj_mode = thrc_pkg::MODE_SPAN;
              else if (adj_mode == thrc_pkg::MODE_SPAN) adj_mode = thrc_pkg::MODE_CENTER;
              disp = 1'b1;
            end
          end
        endcase
        btn_state = nxt;
      end
      thrc_pkg::REQ_LOCK: begin
        if (adj_mode != thrc_pkg::MODE_LOCK) begin
          saved_mode = adj_mode[0];
          adj_mode   = thrc_pkg::MODE_LOCK;
        end
        disp = 1'b1;
      end
      default: begin
        if (adj_mode == thrc_pkg::MODE_LOCK) adj_mode = {1'b0, saved_mode};
        disp = 1'b1;
      end
    endcase
    r = '{cmd: cmd, mode: adj_mode, disp: disp, timer: timer_on, held: btn_state};
  endtask

  always @(posedge clk) begin
    ctrl_result_t want;
    ctrl_result_t got;
    if (!rst_n) begin
      btn_state  = thrc_pkg::ST_IDLE;
      hold_cnt   = '0;
      adj_mode   = thrc_pkg::MODE_CENTER;
      saved_mode = 1'b0;
      timer_on   = 1'b0;
      repeat_thr = thrc_pkg::REPEAT_RESET;
      fast_thr   = thrc_pkg::FAST_RESET;
      both_thr   = thrc_pkg::BOTH_RESET;
      predicted_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        got = '{cmd: out_command, mode: out_adjust_mode, disp: out_display_update,
                timer: out_tick_timer_run, held: out_held_buttons};
        if (predicted_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result cmd=%0d mode=%0d disp=%0b timer=%0b held=%0d",
                     $realtime, got.cmd, got.mode, got.disp, got.timer, got.held);
        end else begin
          want = predicted_results.pop_front();
          if (got.cmd != want.cmd || got.mode != want.mode || got.disp != want.disp ||
              got.timer != want.timer || got.held != want.held) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"%0t: result mismatch cmd %0d/%0d mode %0d/%0d disp %0b/%0b ",
                        "timer %0b/%0b held %0d/%0d (expected/actual)"},
                       $realtime, want.cmd, got.cmd, want.mode, got.mode, want.disp,
                       got.disp, want.timer, got.timer, want.held, got.held);
          end
        end
      end
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[3:2])
          thrc_pkg::REG_REPEAT: repeat_thr = cfg_pwdata[7:0];
          thrc_pkg::REG_FAST:   fast_thr   = cfg_pwdata[7:0];
          thrc_pkg::REG_BOTH:   both_thr   = cfg_pwdata[7:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        predict_result(in_req_type, in_buttons_pressed, want);
        predicted_results.push_back(want);
      end
    end
    pending <= predicted_results.size();
  end

endmodule

// File: tb/two_button_hold_repeat_controller_tb.sv
module two_button_hold_repeat_controller_tb ();
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;

  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_req_type = thrc_pkg::REQ_PRESS;
  logic [1:0]  in_buttons_pressed = 2'b00;

  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_command;
  logic [1:0]  out_adjust_mode;
  logic        out_display_update;
  logic        out_tick_timer_run;
  logic [1:0]  out_held_buttons;

  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [3:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  int mismatches;
  int pending;

  // Idle and stall odds in percent, changed per phase
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int items_sent = 0;

  // Thresholds the block currently holds; used to shape hold lengths
  logic [7:0] rep_ticks  = thrc_pkg::REPEAT_RESET;
  logic [7:0] fast_ticks = thrc_pkg::FAST_RESET;
  logic [7:0] both_ticks = thrc_pkg::BOTH_RESET;

  // Threshold plan per phase: reset values, extremes low, high and zero, then mixes
  logic [7:0] rep_plan  [8] = '{8'd3,  8'd1, 8'd255, 8'd0, 8'd4, 8'd2, 8'd200, 8'd0};
  logic [7:0] fast_plan [8] = '{8'd50, 8'd1, 8'd255, 8'd0, 8'd9, 8'd3, 8'd10, 8'd255};
  logic [7:0] both_plan [8] = '{8'd40, 8'd1, 8'd255, 8'd0, 8'd6, 8'd255, 8'd1, 8'd1};

  always #2 clk = ~clk;

  two_button_hold_repeat_controller i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_req_type        (in_req_type),
    .in_buttons_pressed (in_buttons_pressed),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_command        (out_command),
    .out_adjust_mode    (out_adjust_mode),
    .out_display_update (out_display_update),
    .out_tick_timer_run (out_tick_timer_run),
    .out_held_buttons   (out_held_buttons),
    .cfg_psel           (cfg_psel),
    .cfg_penable        (cfg_penable),
    .cfg_pwrite         (cfg_pwrite),
    .cfg_paddr          (cfg_paddr),
    .cfg_pwdata         (cfg_pwdata),
    .cfg_prdata         (cfg_prdata),
    .cfg_pready         (cfg_pready)
  );

  hold_repeat_checker i_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_req_type        (in_req_type),
    .in_buttons_pressed (in_buttons_pressed),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_command        (out_command),
    .out_adjust_mode    (out_adjust_mode),
    .out_display_update (out_display_update),
    .out_tick_timer_run (out_tick_timer_run),
    .out_held_buttons   (out_held_buttons),
    .cfg_psel           (cfg_psel),
    .cfg_penable        (cfg_penable),
    .cfg_pwrite         (cfg_pwrite),
    .cfg_paddr          (cfg_paddr),
    .cfg_pwdata         (cfg_pwdata),
    .cfg_pready         (cfg_pready),
    .mismatches         (mismatches),
    .pending            (pending)
  );

  // Receiver: stall at random, independent of out_valid
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Offer one item; hold valid and payload until it is taken. Valid stays high on
  // return so a back-to-back item needs no extra assignment in this time step.
  task automatic send_item(input logic [1:0] req, input logic [1:0] lv);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_req_type        <= req;
    in_buttons_pressed <= lv;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // Stop sending and wait until every predicted result has come out. The first
  // edge lets the checker count the item taken at the current edge.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // APB write: setup cycle, then access cycle; the register loads at the edge
  // where psel, penable, pwrite and pready are all high. Return after an edge with
  // psel dropped so a following write starts in a new time step.
  task automatic write_threshold(input logic [1:0] idx, input logic [7:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= {24'd0, val};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Pick a hold length: short in a quarter of picks, otherwise straddling one of the thresholds
  function automatic int pick_hold_len();
    int thr;
    case ($urandom_range(3))
      0: return $urandom_range(6);
      1: thr = int'(rep_ticks);
      2: thr = int'(fast_ticks);
      default: thr = int'(both_ticks);
    endcase
    thr = thr + int'($urandom_range(4)) - 2;
    return (thr < 0) ? 0 : thr;
  endfunction

  // Well-formed hold: press, a run of ticks at the same levels, then a final tick
  // that usually releases. Drop in an occasional lock or unlock mid-hold.
  task automatic run_hold();
    logic [1:0] lv;
    int n;
    lv = 2'($urandom_range(1, 3));
    send_item(thrc_pkg::REQ_PRESS, lv);
    n = pick_hold_len();
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(19) == 0)
        send_item($urandom_range(1) ? thrc_pkg::REQ_LOCK : thrc_pkg::REQ_UNLOCK,
                  2'($urandom_range(3)));
      send_item(thrc_pkg::REQ_TICK, lv);
    end
    send_item(thrc_pkg::REQ_TICK,
              ($urandom_range(3) == 0) ? 2'($urandom_range(1, 3)) : 2'b00);
  endtask

  // Noise: fully random request types and levels
  task automatic run_noise();
    repeat ($urandom_range(1, 4))
      send_item(2'($urandom_range(3)), 2'($urandom_range(3)));
  endtask

  // Idling pattern per phase: none, sender only, receiver only, both
  task automatic set_idling(input int pattern);
    case (pattern)
      0: begin idle_pct = 0;  stall_pct = 0;  end
      1: begin idle_pct = 55; stall_pct = 0;  end
      2: begin idle_pct = 0;  stall_pct = 55; end
      default: begin idle_pct = 37; stall_pct = 37; end
    endcase
  endtask

  // Watchdog
  initial begin
    #4_000_000;
    $display("two_button_hold_repeat_controller_tb: errors");
    $finish;
  end

  initial begin
    int goal;
    // Reset: hold rst_n low at the start, once
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, reset thresholds (repeat 3, fast 50, both 40)
    send_item(thrc_pkg::REQ_TICK, 2'b00);            // tick while idle and timer stopped
    send_item(thrc_pkg::REQ_PRESS, 2'b00);           // press with nothing pressed
    send_item(thrc_pkg::REQ_PRESS, 2'b01);           // left
    repeat (3) send_item(thrc_pkg::REQ_TICK, 2'b01); // step starts at repeat count
    send_item(thrc_pkg::REQ_PRESS, 2'b10);           // right
    repeat (3) send_item(thrc_pkg::REQ_TICK, 2'b10);
    send_item(thrc_pkg::REQ_LOCK, 2'b11);
    send_item(thrc_pkg::REQ_LOCK, 2'b00);            // lock while already locked
    send_item(thrc_pkg::REQ_TICK, 2'b10);            // locked: no command
    send_item(thrc_pkg::REQ_UNLOCK, 2'b01);
    send_item(thrc_pkg::REQ_UNLOCK, 2'b10);          // unlock while not locked
    send_item(thrc_pkg::REQ_PRESS, 2'b11);
    send_item(thrc_pkg::REQ_TICK, 2'b11);
    send_item(thrc_pkg::REQ_TICK, 2'b00);            // early release of both: toggle to span
    send_item(thrc_pkg::REQ_PRESS, 2'b01);
    repeat (3) send_item(thrc_pkg::REQ_TICK, 2'b01); // inc span
    send_item(thrc_pkg::REQ_PRESS, 2'b10);
    repeat (3) send_item(thrc_pkg::REQ_TICK, 2'b10); // dec span
    send_item(thrc_pkg::REQ_LOCK, 2'b00);
    send_item(thrc_pkg::REQ_PRESS, 2'b11);
    send_item(thrc_pkg::REQ_TICK, 2'b00);            // early release while locked stays locked
    send_item(thrc_pkg::REQ_UNLOCK, 2'b00);          // restore span
    drain_results();

    // Random phases; thresholds change only while the block is empty
    for (int ph = 0; ph < 8; ph++) begin
      set_idling(ph % 4);
      if (ph != 0) begin
        rep_ticks  = rep_plan[ph];
        fast_ticks = fast_plan[ph];
        both_ticks = both_plan[ph];
        write_threshold(thrc_pkg::REG_REPEAT, rep_ticks);
        write_threshold(thrc_pkg::REG_FAST, fast_ticks);
        write_threshold(thrc_pkg::REG_BOTH, both_ticks);
      end
      goal = items_sent + 90;
      while (items_sent < goal) begin
        if ($urandom_range(4) == 0) run_noise();
        else run_hold();
        // Hold off now and then until everything in flight has come out
        if ($urandom_range(39) == 0) drain_results();
      end
      drain_results();
    end
    repeat (8) @(posedge clk);

    if (mismatches == 0 && pending == 0) begin
      $display("two_button_hold_repeat_controller_tb: clean");
    end else begin
      $display("two_button_hold_repeat_controller_tb: errors");
    end
    $finish;
  end

endmodule
